// ----- rtl/core/b64d_pkg.sv -----
// Shared types, character constants and the alphabet decode function of the base64 decoder.
package b64d_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       group_last;
    logic       text_last;
  } out_item_t;

  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  byte_count;
    logic        text_last;
  } group_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  localparam logic [7:0] BASE_LOWER   = 8'd26;
  localparam logic [7:0] BASE_DIGIT   = 8'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  localparam logic [1:0] SLOT_LAST    = 2'd3;
  localparam logic [1:0] BYTES_ONE    = 2'd1;
  localparam logic [1:0] BYTES_TWO    = 2'd2;
  localparam logic [1:0] BYTES_THREE  = 2'd3;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t    r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = c - CHAR_UPPER_A;
      r.valid = 1'b1;
      r.value = d[5:0];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = c - CHAR_LOWER_A + BASE_LOWER;
      r.valid = 1'b1;
      r.value = d[5:0];
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      d = c - CHAR_DIGIT_0 + BASE_DIGIT;
      r.valid = 1'b1;
      r.value = d[5:0];
    end else if (c == CHAR_PLUS) begin
      r.valid = 1'b1;
      r.value = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      r.valid = 1'b1;
      r.value = SEXTET_SLASH;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/b64d_front.sv -----
// Front end: accepts characters, gathers each group of up to four and hands closed groups to the queue.
module b64d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  b64d_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output b64d_pkg::group_t  push_data
);
  import b64d_pkg::*;

  logic [1:0]  slot_r, slot_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [2:0]  pad_r, pad_nxt;

  sextet_t     sx;
  logic [23:0] acc_new;
  logic [2:0]  pad_new;
  logic        accept;
  logic        closes;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign closes   = (slot_r == SLOT_LAST) || in_data.end_of_text;

  always_comb begin
    sx      = sextet_of(in_data.in_char);
    acc_new = acc_r;
    pad_new = pad_r;
    if (in_data.in_char == CHAR_PAD) begin
      pad_new = pad_r + 3'd1;
    end else if (sx.valid) begin
      unique case (slot_r)
        2'd0: acc_new[23:18] = acc_r[23:18] | sx.value;
        2'd1: acc_new[17:12] = acc_r[17:12] | sx.value;
        2'd2: acc_new[11:6]  = acc_r[11:6]  | sx.value;
        default: acc_new[5:0] = acc_r[5:0]  | sx.value;
      endcase
    end
  end

  always_comb begin
    push_valid           = accept && closes;
    push_data.word       = acc_new;
    push_data.text_last  = in_data.end_of_text;
    if (pad_new >= 3'd2) begin
      push_data.byte_count = BYTES_ONE;
    end else if (pad_new == 3'd1) begin
      push_data.byte_count = BYTES_TWO;
    end else begin
      push_data.byte_count = BYTES_THREE;
    end

    slot_nxt = slot_r;
    acc_nxt  = acc_r;
    pad_nxt  = pad_r;
    if (accept) begin
      if (closes) begin
        slot_nxt = '0;
        acc_nxt  = '0;
        pad_nxt  = '0;
      end else begin
        slot_nxt = slot_r + 2'd1;
        acc_nxt  = acc_new;
        pad_nxt  = pad_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      acc_r  <= '0;
      pad_r  <= '0;
    end else begin
      slot_r <= slot_nxt;
      acc_r  <= acc_nxt;
      pad_r  <= pad_nxt;
    end
  end

endmodule

// ----- rtl/core/b64d_queue.sv -----
// Short register queue of closed groups between the front and back ends.
module b64d_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  b64d_pkg::group_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output b64d_pkg::group_t pop_data
);
  import b64d_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);

  group_t        store_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != FULL_COUNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/b64d_back.sv -----
// Back end: splits each queued group into its bytes and drives the registered result channel.
module b64d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  b64d_pkg::group_t    pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::out_item_t out_data
);
  import b64d_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign load      = !out_valid_r || out_ready;
  assign is_last   = ((idx_r + 2'd1) == pop_data.byte_count);
  assign pop_ready = load && is_last;

  always_comb begin
    unique case (idx_r)
      2'd0: sel_byte = pop_data.word[23:16];
      2'd1: sel_byte = pop_data.word[15:8];
      2'd2: sel_byte = pop_data.word[7:0];
      default: sel_byte = '0;
    endcase

    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = pop_valid;
      if (pop_valid) begin
        out_item_nxt.out_byte   = sel_byte;
        out_item_nxt.group_last = is_last;
        out_item_nxt.text_last  = pop_data.text_last;
        idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

// ----- rtl/core/base64_stream_decoder_unit.sv -----
// Top level of the streaming base64 decoder: front end, group queue and byte back end.
//
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid/in_ready    in_data   (in_char, end_of_text)
//  out_     output     out_valid/out_ready  out_data  (out_byte, group_last, text_last)
//
// One character is taken per cycle while the group queue has room.
// A closed group gives one to three bytes, one per cycle from the back end's output register
// while the output is not stalled. The first byte of a group is written to the group queue
// at the edge that accepts its closing character, then to the back end's output register.
// Reset is synchronous and clears the partial group, the queue and the output valid flag.
// A stalled output fills the queue; input stalls only once QUEUE_DEPTH groups wait.
module base64_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64d_pkg::out_item_t out_data
);
  import b64d_pkg::*;

  logic   push_valid;
  logic   push_ready;
  group_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  group_t pop_data;

  b64d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/base64_stream_decoder_unit_tb.sv -----
// Self-checking testbench for the streaming base64 decoder with randomised flow control.
`timescale 1ns / 1ps

module base64_stream_decoder_unit_tb;
  import b64d_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  char_queue[$];
  out_item_t expected_bytes[$];
  int        error_count = 0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  int        hold_left = 0;
  logic      hold_request = 1'b0;
  logic      rx_hold;

  logic [1:0]  slot_pos = '0;
  logic [23:0] bit_acc = '0;
  logic [2:0]  pad_cnt = '0;

  base64_stream_decoder_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  assign rx_hold = (hold_left != 0);

  function automatic logic [7:0] char_of_sextet(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (w < BASE_LOWER) return CHAR_UPPER_A + w;
    if (w < BASE_DIGIT) return CHAR_LOWER_A + (w - BASE_LOWER);
    if (v < SEXTET_PLUS) return CHAR_DIGIT_0 + (w - BASE_DIGIT);
    if (v == SEXTET_PLUS) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  task automatic decode_char(input in_item_t item);
    logic [7:0] c;
    logic [5:0] six;
    logic       known;
    int         nbytes;
    out_item_t  result;
    c = item.in_char;
    known = 1'b1;
    six = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      six = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      six = 6'(c - CHAR_LOWER_A + BASE_LOWER);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      six = 6'(c - CHAR_DIGIT_0 + BASE_DIGIT);
    end else if (c == CHAR_PLUS) begin
      six = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      six = SEXTET_SLASH;
    end else begin
      known = 1'b0;
    end
    if (c == CHAR_PAD) begin
      pad_cnt = pad_cnt + 3'd1;
    end else if (known) begin
      bit_acc[23 - 6 * slot_pos -: 6] = bit_acc[23 - 6 * slot_pos -: 6] | six;
    end
    if (slot_pos != SLOT_LAST && !item.end_of_text) begin
      slot_pos = slot_pos + 2'd1;
    end else begin
      nbytes = 1 + ((pad_cnt < 3'd2) ? 1 : 0) + ((pad_cnt < 3'd1) ? 1 : 0);
      for (int k = 0; k < nbytes; k++) begin
        result.out_byte   = bit_acc[23 - 8 * k -: 8];
        result.group_last = (k == nbytes - 1);
        result.text_last  = item.end_of_text;
        expected_bytes = {expected_bytes, result};
      end
      slot_pos = '0;
      bit_acc  = '0;
      pad_cnt  = '0;
    end
  endtask

  task automatic report_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  task automatic check_byte(input out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
      error_count++;
    end else begin
      want = expected_bytes.pop_front();
      report_field("out_byte", want.out_byte, got.out_byte);
      report_field("group_last", want.group_last, got.group_last);
      report_field("text_last", want.text_last, got.text_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_char(in_data);
      if (!in_valid || in_ready) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_data  <= char_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
      if (out_valid && out_ready) check_byte(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  task automatic push_char(input logic [7:0] c, input logic last);
    in_item_t item;
    item.in_char     = c;
    item.end_of_text = last;
    char_queue = {char_queue, item};
  endtask

  task automatic push_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) push_char(s[i], last && (i == s.len() - 1));
  endtask

  // Mostly well-formed encoded strings, with some broken fragments and stray bytes.
  task automatic add_phase(input int target);
    int added;
    int r;
    int len;
    int pads;
    added = 0;
    while (added < target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len  = 4 * $urandom_range(1, 4);
        pads = $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
          push_char((i >= len - pads) ? CHAR_PAD : char_of_sextet(6'($urandom_range(63))),
                    i == len - 1);
        end
      end else if (r < 85) begin
        len = $urandom_range(1, 7);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(3))
            0: push_char(CHAR_PAD, 1'b0);
            1: push_char(8'($urandom_range(255)), 1'b0);
            default: push_char(char_of_sextet(6'($urandom_range(63))), 1'b0);
          endcase
        end
        char_queue[char_queue.size() - 1].end_of_text = ($urandom_range(3) != 0);
      end else begin
        len = 1;
        push_char(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
      added += len;
    end
  endtask

  task automatic drain;
    while (char_queue.size() != 0 || in_valid || expected_bytes.size() != 0) @(negedge clk);
  endtask

  initial begin
    @(posedge clk);
    @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_text("TWFu", 1'b0);
    push_text("+/09", 1'b0);
    push_text("AZaz", 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(8'h80, 1'b0);
    push_char(CHAR_PAD, 1'b0);
    push_text("====", 1'b0);
    push_text("QQ", 1'b1);
    push_text("A", 1'b1);
    push_text("=B", 1'b1);
    drain();

    hold_request = 1'b1;
    while (!rx_hold) @(negedge clk);
    hold_request = 1'b0;
    add_phase(110);
    drain();

    tx_idle_pct = 82;
    add_phase(110);
    drain();

    tx_idle_pct  = 0;
    rx_stall_pct = 82;
    add_phase(110);
    drain();

    tx_idle_pct  = 14;
    rx_stall_pct = 14;
    add_phase(55);
    drain();
    add_phase(55);
    drain();

    repeat (16) @(negedge clk);
    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: timeout with %0d transactions outstanding", $time, expected_bytes.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/b64d_pkg.sv
rtl/core/b64d_front.sv
rtl/core/b64d_queue.sv
rtl/core/b64d_back.sv
rtl/core/base64_stream_decoder_unit.sv
tb/sv/base64_stream_decoder_unit_tb.sv
